// ----- design/dmct_pkg.sv -----
// Package for the debounced multi-click toggle block.
// Holds the transfer payload types, configuration types and register indexes.
// No dependencies.
package dmct_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned MS_W    = 16;
   localparam int unsigned COUNT_W = 4;
   localparam int unsigned CSR_W   = 16;

   typedef enum logic [1:0] {
      CSR_DEBOUNCE_MS     = 2'd0,
      CSR_CLICK_WINDOW_MS = 2'd1,
      CSR_CLICKS_TO_TOGGLE = 2'd2,
      CSR_BOOT_ENABLED    = 2'd3
   } csr_index_type;

   localparam logic [MS_W-1:0]    RST_DEBOUNCE_MS     = 16'd30;
   localparam logic [MS_W-1:0]    RST_CLICK_WINDOW_MS = 16'd600;
   localparam logic [COUNT_W-1:0] RST_CLICKS_TO_TOGGLE = 4'd3;
   localparam logic               RST_BOOT_ENABLED    = 1'b0;

   typedef struct packed {
      logic [TIME_W-1:0] now_ms;
      logic              button_released;
      logic              allow_toggle;
   } req_type;

   typedef struct packed {
      logic               requested_enabled;
      logic               toggled;
      logic               stable_released;
      logic [COUNT_W-1:0] click_tally;
   } rsp_type;

   typedef struct packed {
      logic [MS_W-1:0]    debounce_ms;
      logic [MS_W-1:0]    click_window_ms;
      logic [COUNT_W-1:0] clicks_to_toggle;
      logic               boot_enabled;
   } cfg_type;

endpackage

// ----- design/dmct_csr.sv -----
// Configuration registers of the debounced multi-click toggle block.
// Depends on dmct_pkg.
module dmct_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_we,
   input  dmct_pkg::csr_index_type       csr_index,
   input  logic [dmct_pkg::CSR_W-1:0]    csr_wdata,
   output dmct_pkg::cfg_type             cfg
);

   dmct_pkg::cfg_type cfg_ff;
   dmct_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            dmct_pkg::CSR_DEBOUNCE_MS: begin
               cfg_in.debounce_ms = csr_wdata[dmct_pkg::MS_W-1:0];
            end
            dmct_pkg::CSR_CLICK_WINDOW_MS: begin
               cfg_in.click_window_ms = csr_wdata[dmct_pkg::MS_W-1:0];
            end
            dmct_pkg::CSR_CLICKS_TO_TOGGLE: begin
               cfg_in.clicks_to_toggle = csr_wdata[dmct_pkg::COUNT_W-1:0];
            end
            dmct_pkg::CSR_BOOT_ENABLED: begin
               cfg_in.boot_enabled = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms      <= dmct_pkg::RST_DEBOUNCE_MS;
         cfg_ff.click_window_ms  <= dmct_pkg::RST_CLICK_WINDOW_MS;
         cfg_ff.clicks_to_toggle <= dmct_pkg::RST_CLICKS_TO_TOGGLE;
         cfg_ff.boot_enabled     <= dmct_pkg::RST_BOOT_ENABLED;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/dmct_poll.sv -----
// Debounce and click-run state with its single-pass next-state logic.
// Depends on dmct_pkg.
module dmct_poll (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  dmct_pkg::req_type item,
   input  dmct_pkg::cfg_type cfg,
   output dmct_pkg::rsp_type result
);

   logic                             sampled_ff, sampled_in;
   logic                             stable_ff, stable_in;
   logic                             last_stable_ff, last_stable_in;
   logic [dmct_pkg::TIME_W-1:0]      change_time_ff, change_time_in;
   logic [dmct_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [dmct_pkg::TIME_W-1:0]      window_ff, window_in;
   logic                             flip_ff, flip_in;

   logic [dmct_pkg::TIME_W-1:0]      held;
   logic [dmct_pkg::TIME_W-1:0]      window_age;
   logic [dmct_pkg::COUNT_W-1:0]     count_base;
   logic [dmct_pkg::COUNT_W-1:0]     count_inc;
   logic                             flipped;

   always_comb begin
      sampled_in     = item.button_released;
      change_time_in = (item.button_released != sampled_ff) ? item.now_ms : change_time_ff;
      stable_in      = stable_ff;
      last_stable_in = last_stable_ff;
      count_in       = count_ff;
      window_in      = window_ff;
      flip_in        = flip_ff;
      flipped        = 1'b0;
      count_base     = count_ff;
      count_inc      = '0;
      held           = item.now_ms - change_time_in;
      window_age     = item.now_ms - window_ff;
      if (held >= {{(dmct_pkg::TIME_W-dmct_pkg::MS_W){1'b0}}, cfg.debounce_ms}
          && stable_ff != sampled_in) begin
         stable_in      = sampled_in;
         last_stable_in = sampled_in;
         if (sampled_in && !last_stable_ff) begin
            if (count_ff == '0 || window_age >
                {{(dmct_pkg::TIME_W-dmct_pkg::MS_W){1'b0}}, cfg.click_window_ms}) begin
               window_in  = item.now_ms;
               count_base = '0;
            end
            count_inc = count_base + dmct_pkg::COUNT_W'(1);
            if (count_inc >= cfg.clicks_to_toggle) begin
               if (item.allow_toggle) begin
                  flip_in = !flip_ff;
                  flipped = 1'b1;
               end
               count_in = '0;
            end else begin
               count_in = count_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sampled_ff     <= 1'b1;
         stable_ff      <= 1'b1;
         last_stable_ff <= 1'b1;
         change_time_ff <= '0;
         count_ff       <= '0;
         window_ff      <= '0;
         flip_ff        <= 1'b0;
      end else if (advance) begin
         sampled_ff     <= sampled_in;
         stable_ff      <= stable_in;
         last_stable_ff <= last_stable_in;
         change_time_ff <= change_time_in;
         count_ff       <= count_in;
         window_ff      <= window_in;
         flip_ff        <= flip_in;
      end
   end

   always_comb begin
      result.requested_enabled = cfg.boot_enabled ^ flip_in;
      result.toggled           = flipped;
      result.stable_released   = stable_in;
      result.click_tally       = count_in;
   end

endmodule

// ----- design/debounced_multi_click_toggle_top.sv -----
// Top level of the debounced multi-click toggle block.
// Depends on dmct_pkg, dmct_csr and dmct_poll.
//
// Takes one poll per clock cycle while the result side is not stalled and returns
// exactly one result per poll: the poll is held in an input register, the
// debounce and click logic runs in a single pass from it into the result
// register, and state updates as the result is loaded. Throughput is set by
// that one register-to-register pass.
// A stalled result keeps its register; the input register still takes one
// poll while it is empty, and the input then stalls until the result leaves.
// Reset restores the configuration defaults (30 ms debounce, 600 ms window,
// three clicks, flag off) and the released button state.
module debounced_multi_click_toggle_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  dmct_pkg::req_type             req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output dmct_pkg::rsp_type             rsp_data,
   input  logic                          csr_we,
   input  dmct_pkg::csr_index_type       csr_index,
   input  logic [dmct_pkg::CSR_W-1:0]    csr_wdata
);

   dmct_pkg::cfg_type cfg;
   dmct_pkg::req_type item_ff;
   dmct_pkg::rsp_type result;
   dmct_pkg::rsp_type rsp_ff;
   logic              item_valid_ff;
   logic              rsp_valid_ff;
   logic              advance;

   dmct_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dmct_poll u_poll (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance   = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_ready) begin
            item_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- design/dmct_checker.sv -----
// Port-level checks for the debounced multi-click toggle block.
// Depends on dmct_pkg; bound to debounced_multi_click_toggle_top.
module dmct_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input dmct_pkg::rsp_type          rsp_data
);

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   a_toggle_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.toggled |-> rsp_data.click_tally == '0)
      else $error("toggle left clicks counted");

   a_toggle_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.toggled |-> rsp_data.stable_released)
      else $error("toggle while button pressed");

   a_empty_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result waiting");

endmodule

bind debounced_multi_click_toggle_top dmct_checker u_dmct_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ----- dv/dmct_toggle_checker.sv -----
`timescale 1ns / 100ps
// Checker for the debounced multi-click toggle block: tracks register writes, predicts
// each poll result and compares it with what the block returns. Needs dmct_pkg only.
module dmct_toggle_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  dmct_pkg::req_type          req_data,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  dmct_pkg::rsp_type          rsp_data,
   input  logic                       csr_we,
   input  dmct_pkg::csr_index_type    csr_index,
   input  logic [dmct_pkg::CSR_W-1:0] csr_wdata,
   output int unsigned                pending,
   output int unsigned                fault_count
);

   localparam int unsigned SHOWN_FAULTS = 10;

   dmct_pkg::cfg_type                   knobs;
   logic                                raw_seen;
   logic                                settled;
   logic                                flip_acc;
   logic [dmct_pkg::TIME_W-1:0]         raw_since;
   logic [dmct_pkg::TIME_W-1:0]         window_open;
   logic [dmct_pkg::COUNT_W-1:0]        tally;
   dmct_pkg::rsp_type                   result_q[$];
   int unsigned                         faults;

   function automatic void note_fault(input string msg);
      faults++;
      if (faults <= SHOWN_FAULTS)
         $display("[%0t] %s", $realtime, msg);
   endfunction

   function automatic dmct_pkg::rsp_type poll_outcome(input dmct_pkg::req_type p);
      dmct_pkg::rsp_type           r;
      logic                        flipped;
      logic [dmct_pkg::TIME_W-1:0] held;
      logic [dmct_pkg::TIME_W-1:0] gap;
      flipped = 1'b0;
      if (p.button_released != raw_seen) begin
         raw_seen  = p.button_released;
         raw_since = p.now_ms;
      end
      held = p.now_ms - raw_since;
      gap  = p.now_ms - window_open;
      if (held >= {16'd0, knobs.debounce_ms} && settled != raw_seen) begin
         settled = raw_seen;
         // a settled release is one click
         if (settled) begin
            if (tally == '0 || gap > {16'd0, knobs.click_window_ms}) begin
               window_open = p.now_ms;
               tally       = '0;
            end
            tally = tally + 1'b1;
            if (tally >= knobs.clicks_to_toggle) begin
               if (p.allow_toggle) begin
                  flip_acc = ~flip_acc;
                  flipped  = 1'b1;
               end
               tally = '0;
            end
         end
      end
      r.requested_enabled = knobs.boot_enabled ^ flip_acc;
      r.toggled           = flipped;
      r.stable_released   = settled;
      r.click_tally       = tally;
      return r;
   endfunction

   always @(posedge clock) begin : watch
      dmct_pkg::rsp_type want;
      if (reset) begin
         knobs.debounce_ms      = dmct_pkg::RST_DEBOUNCE_MS;
         knobs.click_window_ms  = dmct_pkg::RST_CLICK_WINDOW_MS;
         knobs.clicks_to_toggle = dmct_pkg::RST_CLICKS_TO_TOGGLE;
         knobs.boot_enabled     = dmct_pkg::RST_BOOT_ENABLED;
         raw_seen    = 1'b1;
         settled     = 1'b1;
         flip_acc    = 1'b0;
         raw_since   = '0;
         window_open = '0;
         tally       = '0;
         result_q.delete();
         faults = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (result_q.size() == 0) begin
               note_fault($sformatf("poll result with none expected: %h", rsp_data));
            end else begin
               want = result_q.pop_front();
               if (want.requested_enabled !== rsp_data.requested_enabled ||
                   want.toggled !== rsp_data.toggled ||
                   want.stable_released !== rsp_data.stable_released ||
                   want.click_tally !== rsp_data.click_tally)
                  note_fault($sformatf({"poll result mismatch: expected en=%0b tog=%0b ",
                     "stable=%0b tally=%0d, got en=%0b tog=%0b stable=%0b tally=%0d"},
                     want.requested_enabled, want.toggled, want.stable_released,
                     want.click_tally, rsp_data.requested_enabled, rsp_data.toggled,
                     rsp_data.stable_released, rsp_data.click_tally));
            end
         end
         if (csr_we) begin
            case (csr_index)
               dmct_pkg::CSR_DEBOUNCE_MS:
                  knobs.debounce_ms      = csr_wdata;
               dmct_pkg::CSR_CLICK_WINDOW_MS:
                  knobs.click_window_ms  = csr_wdata;
               dmct_pkg::CSR_CLICKS_TO_TOGGLE:
                  knobs.clicks_to_toggle = csr_wdata[dmct_pkg::COUNT_W-1:0];
               dmct_pkg::CSR_BOOT_ENABLED:
                  knobs.boot_enabled     = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            result_q.push_back(poll_outcome(req_data));
      end
      pending     <= result_q.size();
      fault_count <= faults;
   end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for the debounced multi-click toggle block: makes polls, register
// writes and result back-pressure, and gives the verdict. Needs dmct_pkg, the RTL and
// dmct_toggle_checker.
module tb_top;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned LONG_HOLD   = 400;
   localparam int unsigned PHASE_POLLS = 85;

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   dmct_pkg::req_type             req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   dmct_pkg::rsp_type             rsp_data;
   logic                          csr_we;
   dmct_pkg::csr_index_type       csr_index;
   logic [dmct_pkg::CSR_W-1:0]    csr_wdata;
   int unsigned                   pending;
   int unsigned                   fault_count;

   dmct_pkg::cfg_type             settings;
   logic [dmct_pkg::TIME_W-1:0]   clock_ms;
   int unsigned                   send_idle_pct = 0;
   int unsigned                   rsp_stall_pct = 0;
   int unsigned                   polls_sent = 0;
   int unsigned                   quiet_cycles = 0;
   logic                          hold_flip = 1'b0;

   debounced_multi_click_toggle_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   dmct_toggle_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .pending     (pending),
      .fault_count (fault_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   task automatic offer_poll(input logic [dmct_pkg::TIME_W-1:0] stamp, input logic level,
                             input logic allow);
      dmct_pkg::req_type p;
      p.now_ms          = stamp;
      p.button_released = level;
      p.allow_toggle    = allow;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (!req_ready);
      polls_sent++;
   endtask

   // press then release, each level held for hold_polls polls spaced 1 to 3 ms beyond one debounce
   task automatic tap(input logic allow, input int unsigned hold_polls);
      logic [dmct_pkg::TIME_W-1:0] step;
      step = {16'd0, settings.debounce_ms} + $urandom_range(1, 3);
      repeat (hold_polls) begin
         offer_poll(clock_ms, 1'b0, allow);
         clock_ms += step;
      end
      repeat (hold_polls) begin
         offer_poll(clock_ms, 1'b1, allow);
         clock_ms += step;
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic apply_settings(input dmct_pkg::cfg_type c);
      logic [dmct_pkg::CSR_W-1:0] junk;
      junk = dmct_pkg::CSR_W'($urandom);
      csr_we    <= 1'b1;
      csr_index <= dmct_pkg::CSR_DEBOUNCE_MS;
      csr_wdata <= c.debounce_ms;
      @(posedge clock);
      csr_index <= dmct_pkg::CSR_CLICK_WINDOW_MS;
      csr_wdata <= c.click_window_ms;
      @(posedge clock);
      csr_index <= dmct_pkg::CSR_CLICKS_TO_TOGGLE;
      csr_wdata <= {junk[dmct_pkg::CSR_W-1:dmct_pkg::COUNT_W], c.clicks_to_toggle};
      @(posedge clock);
      csr_index <= dmct_pkg::CSR_BOOT_ENABLED;
      csr_wdata <= {junk[dmct_pkg::CSR_W-2:0], c.boot_enabled};
      @(posedge clock);
      csr_we   <= 1'b0;
      settings  = c;
   endtask

   initial begin : rsp_side
      logic hold_seen;
      hold_seen = 1'b0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_flip != hold_seen) begin
            hold_seen  = hold_flip;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      dmct_pkg::cfg_type plan;
      int unsigned       phase_end;
      int unsigned       sel;
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_we    = 1'b0;
      csr_index = dmct_pkg::CSR_DEBOUNCE_MS;
      csr_wdata = '0;
      clock_ms  = '0;
      settings.debounce_ms      = dmct_pkg::RST_DEBOUNCE_MS;
      settings.click_window_ms  = dmct_pkg::RST_CLICK_WINDOW_MS;
      settings.clicks_to_toggle = dmct_pkg::RST_CLICKS_TO_TOGGLE;
      settings.boot_enabled     = dmct_pkg::RST_BOOT_ENABLED;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset settings: bounce, wrapping time, three clicks, time stepping back
      offer_poll(32'h0000_0000, 1'b1, 1'b1);
      offer_poll(32'h0000_0005, 1'b0, 1'b1);
      offer_poll(32'h0000_0006, 1'b1, 1'b1);
      offer_poll(32'hFFFF_FFFF, 1'b0, 1'b1);
      offer_poll(32'h0000_001E, 1'b0, 1'b1);
      offer_poll(32'h0000_0020, 1'b1, 1'b1);
      offer_poll(32'h0000_003F, 1'b1, 1'b1);
      clock_ms = 32'h0000_0040;
      tap(1'b1, 2);
      tap(1'b1, 2);
      offer_poll(32'h0000_0200, 1'b0, 1'b1);
      offer_poll(32'h0000_0010, 1'b0, 1'b1);
      clock_ms = 32'h0000_0011;
      drain();

      // zero debounce, one-click target, blocked then allowed flip
      plan = '{16'd0, 16'd0, 4'd1, 1'b1};
      apply_settings(plan);
      tap(1'b0, 1);
      tap(1'b1, 1);
      drain();

      // zero click target with the boot flag cleared
      plan = '{16'd2, 16'd50, 4'd0, 1'b0};
      apply_settings(plan);
      tap(1'b1, 2);

      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph)
            0: plan = '{16'd0, 16'd0, 4'd1, 1'b1};
            1: plan = '{16'hFFFF, 16'hFFFF, 4'd15, 1'b0};
            2: plan = '{16'd3, 16'd120, 4'd0, 1'b1};
            default: begin
               plan.debounce_ms      = dmct_pkg::MS_W'($urandom_range(0, 40));
               plan.click_window_ms  = dmct_pkg::MS_W'(($urandom_range(3) == 0) ? $urandom
                                                       : $urandom_range(100, 900));
               plan.clicks_to_toggle = dmct_pkg::COUNT_W'(($urandom_range(7) == 0) ? 0
                                                          : $urandom_range(1, 6));
               plan.boot_enabled     = 1'($urandom_range(1));
            end
         endcase
         apply_settings(plan);
         case (ph % 4)
            0: begin
               send_idle_pct = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               send_idle_pct = 62;
               rsp_stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               rsp_stall_pct = 62;
            end
            default: begin
               send_idle_pct = 22;
               rsp_stall_pct = 22;
            end
         endcase
         phase_end = polls_sent + PHASE_POLLS;
         // hold the result side off while polls keep coming
         if (ph == 6) begin
            hold_flip <= ~hold_flip;
            repeat (10) tap(1'b1, 2);
         end
         while (polls_sent < phase_end) begin
            sel = $urandom_range(99);
            if (sel < 70) begin
               tap($urandom_range(99) < 80,
                   ($urandom_range(99) < 85) ? 2 : $urandom_range(1, 4));
            end else if (sel < 80) begin
               clock_ms += settings.click_window_ms + $urandom_range(1, 300);
               offer_poll(clock_ms, 1'b1, 1'b1);
            end else if (sel < 92) begin
               repeat ($urandom_range(2, 6)) begin
                  clock_ms += $urandom_range(0, settings.debounce_ms / 2);
                  offer_poll(clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
               end
            end else begin
               clock_ms = $urandom;
               offer_poll(clock_ms, 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fault_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/dmct_pkg.sv
design/dmct_csr.sv
design/dmct_poll.sv
design/debounced_multi_click_toggle_top.sv
design/dmct_checker.sv
dv/dmct_toggle_checker.sv
dv/tb_top.sv
